// File: design/sce_pkg.sv
// Package for the shared cursor edge tracker: beat types, command and edge codes,
// register indexes, reset values and the sequencer state type.
// No dependencies; used by shared_cursor_edge_tracker_core.
package sce_pkg;

	// Command codes
	localparam logic [1:0] CMD_MOVE   = 2'd0;
	localparam logic [1:0] CMD_SCREEN = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;
	localparam logic [1:0] CMD_OTHER  = 2'd3;

	// Entry edge codes
	localparam logic [2:0] EDGE_NONE   = 3'd0;
	localparam logic [2:0] EDGE_LEFT   = 3'd1;
	localparam logic [2:0] EDGE_RIGHT  = 3'd2;
	localparam logic [2:0] EDGE_TOP    = 3'd3;
	localparam logic [2:0] EDGE_BOTTOM = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HEIGHT = 2'd1;

	// Reset values
	localparam logic [15:0] RST_LOCAL_WIDTH  = 16'd1920;
	localparam logic [15:0] RST_LOCAL_HEIGHT = 16'd1080;
	localparam logic [15:0] RST_REMOTE_W     = 16'd1920;
	localparam logic [15:0] RST_REMOTE_H     = 16'd1080;

	// Divider length: one quotient bit per cycle over a 32-bit dividend
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [2:0]         edge_code;
		logic [15:0]        edge_offset;
		logic [15:0]        far_width;
		logic [15:0]        far_height;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        position_issued;
		logic        is_active;
		logic        returned;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} st_t;

endpackage

// File: design/shared_cursor_edge_tracker_core.sv
// Shared cursor edge tracker: sequencer, cursor state and the shared serial divider.
// Depends on sce_pkg.
//
// Usage
//   in_valid/in_ready/in_data carry one event beat (move, screen info, switch,
//   other). out_valid/out_ready/out_data return exactly one result beat per event.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write local_width (index 0) and
//   local_height (index 1); other indexes are dropped. cfg_ready is always high;
//   write only while no event is in flight.
// Sequencing
//   One event at a time. An event is taken in IDLE and worked in EXEC; out_valid
//   rises in DONE, which follows EXEC for most events. A switch onto a known edge
//   with non-zero sizes first scales the offset through the shared restoring
//   divider in DIV, one quotient bit per cycle, before DONE. in_ready returns
//   the cycle after the result beat is taken.
// Reset
//   arst_n clears the sequencer, the active flag and the cursor, and restores
//   the local and far sizes to 1920 x 1080.
// Stall
//   While out_ready is low the result beat is held unchanged and no new event
//   is taken.
module shared_cursor_edge_tracker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sce_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sce_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                       cfg_data
);

	sce_pkg::st_t state_q, state_d;

	logic [15:0] local_w_q, local_h_q;
	logic [15:0] remote_w_q, remote_h_q;
	logic [15:0] cursor_h_q, cursor_v_q;
	logic [2:0]  entry_q;
	logic        active_q, issued_q, back_q;

	sce_pkg::in_item_t item_q;

	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic        to_v_q;
	logic [sce_pkg::DIV_CNT_W-1:0] cnt_q;

	// Clamp of cur + signed d, summed in 18 bits, into [0, size-1] (0 when size is 0)
	function automatic logic [15:0] clamp_axis(input logic [15:0] cur,
		input logic [15:0] d, input logic [15:0] size);
		logic signed [17:0] v;
		logic [15:0]        hi;
		hi = (size == 16'd0) ? 16'd0 : size - 16'd1;
		v  = $signed({2'b00, cur}) + $signed({{2{d[15]}}, d});
		if (v[17])
			return 16'd0;
		else if (v[16:0] > {1'b0, hi})
			return hi;
		else
			return v[15:0];
	endfunction

	function automatic logic [15:0] axis_max(input logic [15:0] size);
		return (size == 16'd0) ? 16'd0 : size - 16'd1;
	endfunction

	// Execute-cycle datapath
	logic [15:0] exe_h, exe_v, exe_rw, exe_rh, exe_far, exe_near;
	logic [2:0]  exe_entry;
	logic        exe_active, exe_issued, exe_back, exe_div, exe_to_v;
	logic [31:0] exe_prod;

	always_comb begin
		exe_h      = cursor_h_q;
		exe_v      = cursor_v_q;
		exe_rw     = remote_w_q;
		exe_rh     = remote_h_q;
		exe_entry  = entry_q;
		exe_active = active_q;
		exe_issued = 1'b0;
		exe_back   = 1'b0;
		exe_div    = 1'b0;
		exe_to_v   = 1'b0;
		exe_far    = remote_h_q;
		exe_near   = local_h_q;
		unique case (item_q.cmd)
			sce_pkg::CMD_MOVE: begin
				if (active_q) begin
					exe_h      = clamp_axis(cursor_h_q, item_q.delta_x, local_w_q);
					exe_v      = clamp_axis(cursor_v_q, item_q.delta_y, local_h_q);
					exe_issued = 1'b1;
					case (entry_q)
						sce_pkg::EDGE_LEFT:   exe_back = (exe_h == 16'd0);
						sce_pkg::EDGE_RIGHT:  exe_back = (exe_h >= axis_max(local_w_q));
						sce_pkg::EDGE_TOP:    exe_back = (exe_v == 16'd0);
						sce_pkg::EDGE_BOTTOM: exe_back = (exe_v >= axis_max(local_h_q));
						default:              exe_back = 1'b0;
					endcase
					if (exe_back)
						exe_active = 1'b0;
				end
			end
			sce_pkg::CMD_SCREEN: begin
				exe_rw = item_q.far_width;
				exe_rh = item_q.far_height;
			end
			sce_pkg::CMD_SWITCH: begin
				exe_active = 1'b1;
				exe_entry  = item_q.edge_code;
				exe_issued = 1'b1;
				case (item_q.edge_code)
					sce_pkg::EDGE_LEFT, sce_pkg::EDGE_RIGHT: begin
						exe_h    = (item_q.edge_code == sce_pkg::EDGE_LEFT) ? 16'd0
							: axis_max(local_w_q);
						exe_v    = 16'd0;
						exe_to_v = 1'b1;
						exe_far  = remote_h_q;
						exe_near = local_h_q;
						exe_div  = (remote_h_q != 16'd0) && (local_h_q != 16'd0);
					end
					sce_pkg::EDGE_TOP, sce_pkg::EDGE_BOTTOM: begin
						exe_v    = (item_q.edge_code == sce_pkg::EDGE_TOP) ? 16'd0
							: axis_max(local_h_q);
						exe_h    = 16'd0;
						exe_far  = remote_w_q;
						exe_near = local_w_q;
						exe_div  = (remote_w_q != 16'd0) && (local_w_q != 16'd0);
					end
					default: begin
						exe_h = {1'b0, local_w_q[15:1]};
						exe_v = {1'b0, local_h_q[15:1]};
					end
				endcase
			end
			default: ;
		endcase
		exe_prod = {16'd0, item_q.edge_offset} * {16'd0, exe_near};
	end

	// Shared divider step
	logic [16:0] div_trial;
	logic        div_ge;
	logic [16:0] div_diff;
	logic [31:0] div_quot;
	logic [15:0] div_sat;
	logic        div_last;

	always_comb begin
		div_trial = {rem_q, dvd_q[31]};
		div_ge    = div_trial >= {1'b0, div_q};
		div_diff  = div_trial - {1'b0, div_q};
		div_quot  = {dvd_q[30:0], div_ge};
		div_sat   = (|div_quot[31:16]) ? 16'hFFFF : div_quot[15:0];
		div_last  = (cnt_q == sce_pkg::DIV_CNT_W'(sce_pkg::DIV_STEPS - 1));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sce_pkg::ST_IDLE: if (in_valid) state_d = sce_pkg::ST_EXEC;
			sce_pkg::ST_EXEC: state_d = exe_div ? sce_pkg::ST_DIV : sce_pkg::ST_DONE;
			sce_pkg::ST_DIV:  if (div_last) state_d = sce_pkg::ST_DONE;
			sce_pkg::ST_DONE: if (out_ready) state_d = sce_pkg::ST_IDLE;
			default:          state_d = sce_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready  = (state_q == sce_pkg::ST_IDLE);
		out_valid = (state_q == sce_pkg::ST_DONE);
		cfg_ready = 1'b1;
		out_data.pos_x           = cursor_h_q;
		out_data.pos_y           = cursor_v_q;
		out_data.position_issued = issued_q;
		out_data.is_active       = active_q;
		out_data.returned        = back_q;
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sce_pkg::ST_IDLE;
			local_w_q  <= sce_pkg::RST_LOCAL_WIDTH;
			local_h_q  <= sce_pkg::RST_LOCAL_HEIGHT;
			remote_w_q <= sce_pkg::RST_REMOTE_W;
			remote_h_q <= sce_pkg::RST_REMOTE_H;
			cursor_h_q <= 16'd0;
			cursor_v_q <= 16'd0;
			entry_q    <= sce_pkg::EDGE_NONE;
			active_q   <= 1'b0;
			issued_q   <= 1'b0;
			back_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sce_pkg::CFG_LOCAL_WIDTH:  local_w_q <= cfg_data;
					sce_pkg::CFG_LOCAL_HEIGHT: local_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == sce_pkg::ST_EXEC) begin
				cursor_h_q <= exe_h;
				cursor_v_q <= exe_v;
				remote_w_q <= exe_rw;
				remote_h_q <= exe_rh;
				entry_q    <= exe_entry;
				active_q   <= exe_active;
				issued_q   <= exe_issued;
				back_q     <= exe_back;
				cnt_q      <= '0;
			end
			if (state_q == sce_pkg::ST_DIV) begin
				cnt_q <= cnt_q + sce_pkg::DIV_CNT_W'(1);
				if (div_last) begin
					if (to_v_q)
						cursor_v_q <= div_sat;
					else
						cursor_h_q <= div_sat;
				end
			end
		end
	end

	// Item capture and divider datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_data;
		if (state_q == sce_pkg::ST_EXEC) begin
			dvd_q  <= exe_prod;
			rem_q  <= 16'd0;
			div_q  <= exe_far;
			to_v_q <= exe_to_v;
		end else if (state_q == sce_pkg::ST_DIV) begin
			dvd_q <= div_quot;
			rem_q <= div_ge ? div_diff[15:0] : div_trial[15:0];
		end
	end

	// Checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open together");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sce_pkg::ST_DIV && div_last) |=> (state_q == sce_pkg::ST_DONE))
		else $error("divider did not finish after its last step");

	a_return_drops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.returned |-> !out_data.is_active && out_data.position_issued)
		else $error("return beat with active flag still set");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sce_pkg::ST_EXEC))
		else $error("accepted beat not executed");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sce_pkg::ST_DIV) |-> (rem_q < div_q))
		else $error("divider remainder out of range");

endmodule

// File: bench/shared_cursor_edge_tracker_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for shared_cursor_edge_tracker_core: directed and random event beats,
// an in-bench cursor tracker that predicts every result beat, and config sweeps between phases.
// Depends on sce_pkg and the shared_cursor_edge_tracker_core RTL.
module shared_cursor_edge_tracker_core_tb;

	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned END_CYCLES    = 40;

	// indexes past the last register, written to show they are dropped
	localparam logic [sce_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO =
		sce_pkg::CFG_LOCAL_HEIGHT + sce_pkg::CFG_IDX_W'(1);
	localparam logic [sce_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	sce_pkg::in_item_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	sce_pkg::out_item_t            out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sce_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                   cfg_data  = '0;

	shared_cursor_edge_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Tracked copy of the cursor state and the screen sizes
	logic        trk_active = 1'b0;
	logic [15:0] trk_x      = '0;
	logic [15:0] trk_y      = '0;
	logic [2:0]  trk_side   = sce_pkg::EDGE_NONE;
	logic [15:0] far_w      = sce_pkg::RST_REMOTE_W;
	logic [15:0] far_h      = sce_pkg::RST_REMOTE_H;
	logic [15:0] loc_w      = sce_pkg::RST_LOCAL_WIDTH;
	logic [15:0] loc_h      = sce_pkg::RST_LOCAL_HEIGHT;

	sce_pkg::in_item_t  event_q[$];
	sce_pkg::out_item_t cursor_due_q[$];
	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int          fail_count   = 0;
	logic        in_taken     = 1'b0;
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_req     = 0;
	int unsigned hold_ack     = 0;
	int unsigned hold_left    = 0;
	int unsigned quiet_cycles = 0;

	// far-to-local offset scaling, saturating at 16 bits
	function automatic logic [15:0] scale_offset(logic [15:0] off, logic [15:0] far_sz,
			logic [15:0] near_sz);
		logic [31:0] q;
		if (far_sz == 16'd0 || near_sz == 16'd0)
			return '0;
		q = (32'(off) * 32'(near_sz)) / 32'(far_sz);
		return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [15:0] axis_top(logic [15:0] sz);
		return (sz == 16'd0) ? 16'd0 : sz - 16'd1;
	endfunction

	function automatic logic [15:0] clamp_axis_pos(logic [15:0] cur, logic signed [15:0] d,
			logic [15:0] sz);
		int cur_i;
		int d_i;
		int v;
		cur_i = int'(cur);
		d_i   = int'(d);
		v     = cur_i + d_i;
		if (v > int'(axis_top(sz)))
			v = int'(axis_top(sz));
		if (v < 0)
			v = 0;
		return 16'(v);
	endfunction

	// Apply one event to the tracked state and return the result beat it should give
	function automatic sce_pkg::out_item_t advance_cursor(sce_pkg::in_item_t it);
		sce_pkg::out_item_t res;
		logic               issued;
		logic               back;
		issued = 1'b0;
		back   = 1'b0;
		case (it.cmd)
			sce_pkg::CMD_MOVE: if (trk_active) begin
				trk_x  = clamp_axis_pos(trk_x, it.delta_x, loc_w);
				trk_y  = clamp_axis_pos(trk_y, it.delta_y, loc_h);
				issued = 1'b1;
				case (trk_side)
					sce_pkg::EDGE_LEFT:   back = (trk_x == 16'd0);
					sce_pkg::EDGE_RIGHT:  back = (trk_x >= axis_top(loc_w));
					sce_pkg::EDGE_TOP:    back = (trk_y == 16'd0);
					sce_pkg::EDGE_BOTTOM: back = (trk_y >= axis_top(loc_h));
					default:              back = 1'b0;
				endcase
				if (back)
					trk_active = 1'b0;
			end
			sce_pkg::CMD_SCREEN: begin
				far_w = it.far_width;
				far_h = it.far_height;
			end
			sce_pkg::CMD_SWITCH: begin
				trk_active = 1'b1;
				trk_side   = it.edge_code;
				issued     = 1'b1;
				case (it.edge_code)
					sce_pkg::EDGE_LEFT: begin
						trk_x = '0;
						trk_y = scale_offset(it.edge_offset, far_h, loc_h);
					end
					sce_pkg::EDGE_RIGHT: begin
						trk_x = axis_top(loc_w);
						trk_y = scale_offset(it.edge_offset, far_h, loc_h);
					end
					sce_pkg::EDGE_TOP: begin
						trk_x = scale_offset(it.edge_offset, far_w, loc_w);
						trk_y = '0;
					end
					sce_pkg::EDGE_BOTTOM: begin
						trk_x = scale_offset(it.edge_offset, far_w, loc_w);
						trk_y = axis_top(loc_h);
					end
					// unknown edge: centre of the local screen
					default: begin
						trk_x = loc_w >> 1;
						trk_y = loc_h >> 1;
					end
				endcase
			end
			default: ;
		endcase
		res.pos_x           = trk_x;
		res.pos_y           = trk_y;
		res.position_issued = issued;
		res.is_active       = trk_active;
		res.returned        = back;
		return res;
	endfunction

	// Stimulus builders; unused fields carry random noise
	function automatic sce_pkg::in_item_t mk_cmd(logic [1:0] c);
		sce_pkg::in_item_t it;
		it             = '0;
		it.delta_x     = 16'($urandom);
		it.delta_y     = 16'($urandom);
		it.edge_code   = 3'($urandom);
		it.edge_offset = 16'($urandom);
		it.far_width   = 16'($urandom);
		it.far_height  = 16'($urandom);
		it.cmd         = c;
		return it;
	endfunction

	function automatic sce_pkg::in_item_t mk_move(logic signed [15:0] dx,
			logic signed [15:0] dy);
		sce_pkg::in_item_t it;
		it         = mk_cmd(sce_pkg::CMD_MOVE);
		it.delta_x = dx;
		it.delta_y = dy;
		return it;
	endfunction

	function automatic sce_pkg::in_item_t mk_screen(logic [15:0] w, logic [15:0] h);
		sce_pkg::in_item_t it;
		it            = mk_cmd(sce_pkg::CMD_SCREEN);
		it.far_width  = w;
		it.far_height = h;
		return it;
	endfunction

	function automatic sce_pkg::in_item_t mk_switch(logic [2:0] code, logic [15:0] off);
		sce_pkg::in_item_t it;
		it             = mk_cmd(sce_pkg::CMD_SWITCH);
		it.edge_code   = code;
		it.edge_offset = off;
		return it;
	endfunction

	function automatic logic signed [15:0] random_delta();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 16'(int'($urandom_range(128)) - 64);
		if (pick < 60)
			return 16'(int'($urandom_range(2000)) - 1000);
		if (pick < 75) begin
			case ($urandom_range(4))
				0:       return 16'h8000;
				1:       return 16'h7FFF;
				2:       return 16'h0000;
				3:       return 16'hFFFF;
				default: return 16'h0001;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] random_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 16'd0;
		if (pick < 20)
			return 16'd1;
		if (pick < 50)
			return 16'($urandom_range(4000));
		if (pick < 65)
			return 16'hFFFF - 16'($urandom_range(3));
		return 16'($urandom);
	endfunction

	// Mostly moves, with some switches, screen info and dead events
	function automatic sce_pkg::in_item_t random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 62)
			return mk_move(random_delta(), random_delta());
		if (pick < 80)
			return mk_switch(($urandom_range(9) < 8)
					? 3'(sce_pkg::EDGE_LEFT + $urandom_range(3))
					: 3'($urandom_range(7)), random_size());
		if (pick < 92)
			return mk_screen(random_size(), random_size());
		return mk_cmd(sce_pkg::CMD_OTHER);
	endfunction

	task automatic queue_item(sce_pkg::in_item_t it);
		event_q.push_back(it);
		items_queued++;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Wait until every queued beat is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (items_taken != items_queued || cursor_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [sce_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == sce_pkg::CFG_LOCAL_WIDTH)
			loc_w = val;
		else if (idx == sce_pkg::CFG_LOCAL_HEIGHT)
			loc_h = val;
	endtask

	task automatic set_screen(logic [15:0] w, logic [15:0] h, bit spare);
		write_reg(sce_pkg::CFG_LOCAL_WIDTH, w);
		write_reg(sce_pkg::CFG_LOCAL_HEIGHT, h);
		if (spare) begin
			write_reg(CFG_SPARE_LO, 16'($urandom));
			write_reg(CFG_SPARE_HI, 16'($urandom));
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int unsigned n, int unsigned tx_pct, int unsigned rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (n) queue_item(random_item());
		drain();
	endtask

	// Sequence of phases
	initial begin : stim
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed events on the reset screen sizes
		queue_item(mk_move(16'sh7FFF, 16'sh8000));     // ignored while inactive
		queue_item(mk_cmd(sce_pkg::CMD_OTHER));
		queue_item(mk_switch(sce_pkg::EDGE_NONE, 16'hFFFF));    // centred
		queue_item(mk_move(16'sh8000, 16'sh7FFF));
		queue_item(mk_move(16'sh7FFF, 16'sh8000));
		queue_item(mk_screen(16'hFFFF, 16'hFFFF));
		queue_item(mk_switch(sce_pkg::EDGE_LEFT, 16'hFFFF));    // lands past the bottom
		queue_item(mk_move(16'sd0, 16'sd0));           // back on the left edge
		queue_item(mk_move(16'sd1, 16'sd1));
		queue_item(mk_switch(sce_pkg::EDGE_RIGHT, 16'd0));
		queue_item(mk_move(-16'sd5, 16'sd3));
		queue_item(mk_move(16'sd100, 16'sd0));
		queue_item(mk_screen(16'd1, 16'd1));
		queue_item(mk_switch(sce_pkg::EDGE_TOP, 16'hFFFF));     // scaled offset saturates
		queue_item(mk_move(16'sd0, 16'sd5));
		queue_item(mk_move(16'sd0, 16'sh8000));
		queue_item(mk_screen(16'd0, 16'd0));
		queue_item(mk_switch(sce_pkg::EDGE_BOTTOM, 16'd1234));  // far size zero
		queue_item(mk_move(16'sd3, 16'sd1));
		queue_item(mk_switch(3'd5, 16'd77));
		queue_item(mk_move(16'sh8000, 16'sh8000));     // unknown edge never returns
		queue_item(mk_switch(3'd7, 16'd0));
		queue_item(mk_switch(3'd6, 16'hFFFF));
		queue_item(mk_screen(16'd1920, 16'd0));
		queue_item(mk_switch(sce_pkg::EDGE_LEFT, 16'd500));
		drain();

		set_screen(16'hFFFF, 16'hFFFF, 1'b0);
		run_phase(60, 0, 0);

		set_screen(16'd1, 16'd1, 1'b0);
		run_phase(50, 50, 0);

		// zero local size, plus writes to indexes that do not exist
		set_screen(16'd0, 16'd0, 1'b1);
		run_phase(50, 0, 50);

		// long receiver hold-off while the sender keeps offering
		set_screen(16'd800, 16'd600, 1'b0);
		hold_req++;
		run_phase(60, 8, 8);

		set_screen(16'($urandom_range(4000, 2)), 16'($urandom_range(4000, 2)), 1'b0);
		run_phase(80, 0, 0);

		set_screen(16'd1920, 16'd0, 1'b0);
		run_phase(75, 8, 8);

		repeat (END_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Event driver: new beat only once the previous one is taken
	always @(negedge clk) begin : feed
		logic              nxt_valid;
		sce_pkg::in_item_t nxt_data;
		nxt_valid = in_valid;
		nxt_data  = in_data;
		if (in_taken || !in_valid) begin
			nxt_valid = 1'b0;
			if (event_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt_valid = 1'b1;
				nxt_data  = event_q.pop_front();
			end
		end
		in_valid <= nxt_valid;
		in_data  <= nxt_data;
	end

	// Result receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin : sink
		if (hold_ack != hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_ack  = hold_req;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Monitor: check result beats first, then predict from the accepted event beat
	always @(posedge clk) begin : watch
		sce_pkg::out_item_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cursor_due_q.size() == 0) begin
					$display("%0t: result beat 0x%h with nothing expected", $time, out_data);
					fail_count++;
				end else begin
					want = cursor_due_q.pop_front();
					check_field("pos_x", want.pos_x, out_data.pos_x);
					check_field("pos_y", want.pos_y, out_data.pos_y);
					check_field("position_issued", 16'(want.position_issued),
							16'(out_data.position_issued));
					check_field("is_active", 16'(want.is_active), 16'(out_data.is_active));
					check_field("returned", 16'(want.returned), 16'(out_data.returned));
				end
			end
			if (in_valid && in_ready) begin
				cursor_due_q.push_back(advance_cursor(in_data));
				items_taken++;
			end
		end
	end

	// Watchdog on cycles with no beat moving on any channel
	always @(posedge clk) begin : dog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule

// File: files.f
design/sce_pkg.sv
design/shared_cursor_edge_tracker_core.sv
bench/shared_cursor_edge_tracker_core_tb.sv
